@@ src/uer_pkg.sv @@
package uer_pkg;

  // event codes
  localparam logic [1:0] FUNC_START    = 2'd0;
  localparam logic [1:0] FUNC_CAPTURE  = 2'd1;
  localparam logic [1:0] FUNC_OVERFLOW = 2'd2;
  localparam logic [1:0] FUNC_TICK     = 2'd3;

  // phase codes, also the mode field
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_WAIT    = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  localparam int unsigned UER_COUNTER_WIDTH = 16;
  localparam int unsigned CAPTURE_W         = 16;
  localparam int unsigned DIST_W            = 16;
  localparam int unsigned OVF_W             = 16;
  localparam int unsigned MS_W              = 8;

  localparam logic [MS_W-1:0] TIMEOUT_RESET = 8'd30;

  // distance = floor(width * 17 / 1000), saturating at 16 bits
  localparam int unsigned ECHO_MUL  = 17;
  // smallest width whose distance no longer fits in 16 bits
  localparam int unsigned SAT_WIDTH = 3855059;
  localparam int unsigned SAT_BITS  = 22;
  localparam int unsigned SCALED_W  = 26;
  // reciprocal of 1000, exact for scaled values below 2**26
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 27'd68719477;
  localparam int unsigned PROD_W      = SCALED_W + RECIP_W;

endpackage

@@ src/ultrasonic_echo_ranger.sv @@
// Echo-ranging controller. Each input beat is one event (start, echo edge capture, timer
// overflow or millisecond tick) and gives exactly one result beat with the last valid
// distance, the phase after the event and three event flags. One event is taken per clock
// while the result side is not stalled; a beat passes through an input register and then a
// result register before its result shows on the outputs. The width-to-distance step (times
// 17, divided by 1000 through a reciprocal multiply) sits between those two registers. The
// timeout register is written through the cfg channel, which is always ready.
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = UER_COUNTER_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           func,
  input  logic [CAPTURE_W-1:0] capture_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DIST_W-1:0]    distance_cm,
  output logic [1:0]           mode,
  output logic                 new_distance,
  output logic                 trigger_pulse,
  output logic                 timed_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [MS_W-1:0]      cfg_data
);

  localparam int unsigned CAP_BITS = (COUNTER_WIDTH < CAPTURE_W) ? COUNTER_WIDTH : CAPTURE_W;
  localparam int unsigned UP_W     = OVF_W + COUNTER_WIDTH;
  localparam logic [UP_W-1:0] SAT_LIM = UP_W'(SAT_WIDTH);

  // configuration
  logic [MS_W-1:0] timeout_ms;

  // input register
  logic                s1_valid;
  logic [1:0]          s1_func;
  logic [CAP_BITS-1:0] s1_cap;

  // block state
  logic [1:0]          phase, phase_next;
  logic                rising_seen, rising_seen_next;
  logic [CAP_BITS-1:0] rising_capture, rising_capture_next;
  logic [OVF_W-1:0]    overflow_count, overflow_count_next;
  logic [MS_W-1:0]     elapsed_ms, elapsed_ms_next;
  logic [DIST_W-1:0]   last_distance, last_distance_next;

  logic newd_next, trig_next, tmo_next;
  logic out_free, s1_fire, in_fire;

  // width and distance datapath
  logic [UP_W-1:0]     up;
  logic [UP_W:0]       diff;
  logic                width_neg, width_sat;
  logic [SAT_BITS-1:0] w_low;
  logic [SCALED_W-1:0] scaled;
  logic [PROD_W-1:0]   prod;
  logic [DIST_W-1:0]   echo_cm;

  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign up        = {overflow_count, COUNTER_WIDTH'(s1_cap)};
  assign diff      = {1'b0, up} - {1'b0, UP_W'(rising_capture)};
  assign width_neg = diff[UP_W];
  assign width_sat = !width_neg && (diff[UP_W-1:0] >= SAT_LIM);
  assign w_low     = width_neg ? '0 : diff[SAT_BITS-1:0];
  // times 17 as shift and add
  assign scaled    = SCALED_W'({w_low, 4'b0000}) + SCALED_W'(w_low);
  assign prod      = PROD_W'(scaled) * PROD_W'(RECIP_MUL);
  assign echo_cm   = width_sat ? {DIST_W{1'b1}} : prod[RECIP_SHIFT +: DIST_W];

  always_comb begin
    phase_next          = phase;
    rising_seen_next    = rising_seen;
    rising_capture_next = rising_capture;
    overflow_count_next = overflow_count;
    elapsed_ms_next     = elapsed_ms;
    last_distance_next  = last_distance;
    newd_next           = 1'b0;
    trig_next           = 1'b0;
    tmo_next            = 1'b0;
    unique case (s1_func)
      FUNC_START: begin
        if (phase != MODE_WAIT) begin
          overflow_count_next = '0;
          elapsed_ms_next     = '0;
          phase_next          = MODE_WAIT;
          trig_next           = 1'b1;
        end
      end
      FUNC_CAPTURE: begin
        if (!rising_seen) begin
          rising_capture_next = s1_cap;
          overflow_count_next = '0;
          rising_seen_next    = 1'b1;
        end else begin
          rising_seen_next = 1'b0;
          if (phase == MODE_WAIT) begin
            last_distance_next = echo_cm;
            phase_next         = MODE_IDLE;
            newd_next          = 1'b1;
          end
        end
      end
      FUNC_OVERFLOW: begin
        if (overflow_count != {OVF_W{1'b1}}) begin
          overflow_count_next = overflow_count + 1'b1;
        end
      end
      FUNC_TICK: begin
        if (phase == MODE_WAIT) begin
          if (elapsed_ms != {MS_W{1'b1}}) begin
            elapsed_ms_next = elapsed_ms + 1'b1;
          end
          if (elapsed_ms_next > timeout_ms) begin
            phase_next = MODE_TIMEOUT;
            tmo_next   = 1'b1;
          end
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms     <= TIMEOUT_RESET;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      phase          <= MODE_IDLE;
      rising_seen    <= 1'b0;
      rising_capture <= '0;
      overflow_count <= '0;
      elapsed_ms     <= '0;
      last_distance  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_ms <= cfg_data;
      end
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (s1_fire) begin
        phase          <= phase_next;
        rising_seen    <= rising_seen_next;
        rising_capture <= rising_capture_next;
        overflow_count <= overflow_count_next;
        elapsed_ms     <= elapsed_ms_next;
        last_distance  <= last_distance_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func <= func;
      s1_cap  <= capture_value[CAP_BITS-1:0];
    end
    if (s1_fire) begin
      distance_cm   <= last_distance_next;
      mode          <= phase_next;
      new_distance  <= newd_next;
      trigger_pulse <= trig_next;
      timed_out     <= tmo_next;
    end
  end

  a_trig_waits: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger_pulse |-> mode == MODE_WAIT)
    else $error("trigger beat not left in wait phase");

  a_meas_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_distance |-> mode == MODE_IDLE)
    else $error("measurement beat not left in idle phase");

  a_tmo_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && timed_out |-> mode == MODE_TIMEOUT)
    else $error("timeout beat not left in timeout phase");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({new_distance, trigger_pulse, timed_out}))
    else $error("more than one event flag in a result beat");

endmodule

@@ bench/ultrasonic_echo_ranger_checker.sv @@
module ultrasonic_echo_ranger_checker
  import uer_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           func,
  input  logic [CAPTURE_W-1:0] capture_value,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [DIST_W-1:0]    distance_cm,
  input  logic [1:0]           mode,
  input  logic                 new_distance,
  input  logic                 trigger_pulse,
  input  logic                 timed_out,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [MS_W-1:0]      cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        mode_code;
    logic              new_dist;
    logic              trig;
    logic              tmo;
  } reading_t;

  reading_t expected_readings[$];

  // predicted block state
  logic [MS_W-1:0]      timeout_ms;
  logic [1:0]           phase;
  logic                 rising_seen;
  logic [CAPTURE_W-1:0] rising_capture;
  logic [OVF_W-1:0]     overflow_count;
  logic [MS_W-1:0]      elapsed_ms;
  logic [DIST_W-1:0]    last_distance;

  function automatic logic [DIST_W-1:0] echo_to_cm(longint unsigned echo_width);
    longint unsigned cm;
    cm = echo_width * 17 / 1000;
    return (cm > 65535) ? '1 : cm[DIST_W-1:0];
  endfunction

  function automatic reading_t apply_event(logic [1:0] f, logic [CAPTURE_W-1:0] cap);
    reading_t r;
    longint unsigned falling_abs;
    r = '0;
    case (f)
      FUNC_START: begin
        if (phase != MODE_WAIT) begin
          overflow_count = '0;
          elapsed_ms = '0;
          phase = MODE_WAIT;
          r.trig = 1'b1;
        end
      end
      FUNC_CAPTURE: begin
        if (!rising_seen) begin
          rising_capture = cap;
          overflow_count = '0;
          rising_seen = 1'b1;
        end else begin
          rising_seen = 1'b0;
          if (phase == MODE_WAIT) begin
            // falling edge position counting whole timer wraps
            falling_abs = 64'(overflow_count);
            falling_abs = (falling_abs << UER_COUNTER_WIDTH) + 64'(cap);
            last_distance = (falling_abs >= 64'(rising_capture)) ?
                            echo_to_cm(falling_abs - 64'(rising_capture)) : '0;
            phase = MODE_IDLE;
            r.new_dist = 1'b1;
          end
        end
      end
      FUNC_OVERFLOW: begin
        if (overflow_count != '1) overflow_count++;
      end
      default: begin
        if (phase == MODE_WAIT) begin
          if (elapsed_ms != '1) elapsed_ms++;
          if (elapsed_ms > timeout_ms) begin
            phase = MODE_TIMEOUT;
            r.tmo = 1'b1;
          end
        end
      end
    endcase
    r.distance = last_distance;
    r.mode_code = phase;
    return r;
  endfunction

  task automatic note_mismatch(string field, int unsigned want, int unsigned got);
    $error("%s: expected %0d, got %0d", field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      timeout_ms = TIMEOUT_RESET;
      phase = MODE_IDLE;
      rising_seen = 1'b0;
      rising_capture = '0;
      overflow_count = '0;
      elapsed_ms = '0;
      last_distance = '0;
      fail_count = 0;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) timeout_ms = cfg_data;
      if (in_valid && !in_stall) expected_readings.push_back(apply_event(func, capture_value));
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $error("result beat with no event outstanding");
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          if (distance_cm !== want.distance)
            note_mismatch("distance_cm", want.distance, distance_cm);
          if (mode !== want.mode_code) note_mismatch("mode", want.mode_code, mode);
          if (new_distance !== want.new_dist)
            note_mismatch("new_distance", want.new_dist, new_distance);
          if (trigger_pulse !== want.trig)
            note_mismatch("trigger_pulse", want.trig, trigger_pulse);
          if (timed_out !== want.tmo) note_mismatch("timed_out", want.tmo, timed_out);
        end
      end
    end
    pending = expected_readings.size();
  end

endmodule

@@ bench/ultrasonic_echo_ranger_tb.sv @@
module ultrasonic_echo_ranger_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uer_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_BEATS = 200;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           func = FUNC_START;
  logic [CAPTURE_W-1:0] capture_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DIST_W-1:0]    distance_cm;
  logic [1:0]           mode;
  logic                 new_distance;
  logic                 trigger_pulse;
  logic                 timed_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [MS_W-1:0]      cfg_data = TIMEOUT_RESET;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int timeout_now = int'(TIMEOUT_RESET);
  int phase_beats = 0;
  bit next_is_falling = 1'b0;

  ultrasonic_echo_ranger dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .capture_value(capture_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .distance_cm(distance_cm), .mode(mode), .new_distance(new_distance),
    .trigger_pulse(trigger_pulse), .timed_out(timed_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ultrasonic_echo_ranger_checker ranging_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .capture_value(capture_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .distance_cm(distance_cm), .mode(mode), .new_distance(new_distance),
    .trigger_pulse(trigger_pulse), .timed_out(timed_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_event(input logic [1:0] f, input logic [CAPTURE_W-1:0] c);
    bit taken;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    capture_value <= c;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (f == FUNC_CAPTURE) next_is_falling = !next_is_falling;
    phase_beats++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_timeout(input logic [MS_W-1:0] v);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    timeout_now = int'(v);
  endtask

  // falling edge first if one is due, then start, rising edge, some wraps and ticks, falling edge
  task automatic measure();
    int wraps;
    int ticks;
    if (next_is_falling) send_event(FUNC_CAPTURE, CAPTURE_W'($urandom));
    send_event(FUNC_START, CAPTURE_W'($urandom));
    send_event(FUNC_CAPTURE, CAPTURE_W'($urandom));
    wraps = ($urandom_range(9) == 0) ? $urandom_range(55, 80) : $urandom_range(0, 3);
    ticks = $urandom_range(0, 3);
    while (wraps + ticks > 0) begin
      if (ticks == 0 || (wraps > 0 && $urandom_range(1) == 0)) begin
        send_event(FUNC_OVERFLOW, CAPTURE_W'($urandom));
        wraps--;
      end else begin
        send_event(FUNC_TICK, CAPTURE_W'($urandom));
        ticks--;
      end
    end
    send_event(FUNC_CAPTURE, CAPTURE_W'($urandom));
  endtask

  task automatic run_to_timeout();
    int ticks;
    send_event(FUNC_START, CAPTURE_W'($urandom));
    ticks = (timeout_now <= 40 || $urandom_range(9) == 0) ? timeout_now + 1 :
            $urandom_range(1, 4);
    repeat (ticks) send_event(FUNC_TICK, CAPTURE_W'($urandom));
    if ($urandom_range(1)) send_event(FUNC_TICK, CAPTURE_W'($urandom));
    if ($urandom_range(1)) send_event(FUNC_CAPTURE, CAPTURE_W'($urandom));
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [MS_W-1:0] settings[8];
    int roll;
    settings = '{8'd1, 8'd255, 8'd0, 8'd30, 8'd2, 8'd254, 8'd17, 8'd5};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // idle events, edges outside a measurement, repeated start
    send_event(FUNC_TICK, 16'h0000);
    send_event(FUNC_OVERFLOW, 16'hFFFF);
    send_event(FUNC_CAPTURE, 16'h1234);
    send_event(FUNC_CAPTURE, 16'h4321);
    send_event(FUNC_START, 16'h0000);
    send_event(FUNC_START, 16'hFFFF);
    // echo across one wrap
    send_event(FUNC_CAPTURE, 16'hFFFF);
    send_event(FUNC_OVERFLOW, 16'h0000);
    send_event(FUNC_CAPTURE, 16'h0000);
    send_event(FUNC_START, 16'h0000);
    send_event(FUNC_CAPTURE, 16'h0000);
    send_event(FUNC_CAPTURE, 16'hFFFF);
    // falling before rising without a wrap clamps to zero
    send_event(FUNC_START, 16'h0000);
    send_event(FUNC_CAPTURE, 16'h8000);
    send_event(FUNC_CAPTURE, 16'h0100);
    // rising edge before the start, edge order carries over
    send_event(FUNC_CAPTURE, 16'h00FF);
    send_event(FUNC_START, 16'h0000);
    send_event(FUNC_CAPTURE, 16'h9000);
    drain();

    // zero timeout: first tick times out, restart from timeout
    write_timeout(8'd0);
    send_event(FUNC_START, 16'h0000);
    send_event(FUNC_TICK, 16'h0000);
    send_event(FUNC_TICK, 16'h0000);
    send_event(FUNC_START, 16'h0000);
    send_event(FUNC_TICK, 16'h0000);
    drain();

    // elapsed count saturates and never passes the largest timeout
    write_timeout(8'd255);
    send_event(FUNC_START, 16'h0000);
    repeat (260) send_event(FUNC_TICK, 16'h0000);
    send_event(FUNC_CAPTURE, 16'h0000);
    send_event(FUNC_CAPTURE, 16'hFFFF);
    // long echo, distance saturates
    send_event(FUNC_START, 16'h0000);
    send_event(FUNC_CAPTURE, 16'h0000);
    repeat (60) send_event(FUNC_OVERFLOW, 16'h0000);
    send_event(FUNC_CAPTURE, 16'hFFFF);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_timeout(settings[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 63;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 63;
        end
        default: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
        roll = $urandom_range(99);
        if (roll < 60) measure();
        else if (roll < 80) run_to_timeout();
        else repeat ($urandom_range(1, 4))
          send_event(2'($urandom_range(3)), CAPTURE_W'($urandom));
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
